@@ rtl/ffsa_pkg.sv @@
`timescale 1ns / 1ps
package ffsa_pkg;

  // Heap geometry.
  localparam int unsigned HeapBytes   = 16777216;
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned MaxBlocks   = 1024;

  localparam int unsigned AddrW  = $clog2(MaxBlocks);
  localparam int unsigned LinkW  = AddrW + 1;
  localparam int unsigned StartW = 24;
  localparam int unsigned SizeW  = 25;
  localparam int unsigned ReqW   = 25;
  localparam int unsigned SzW    = ReqW + 1;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 56;

  localparam logic [LinkW-1:0]  EndMark    = LinkW'(MaxBlocks);
  localparam logic [SizeW-1:0]  HdrSize    = SizeW'(HeaderBytes);
  localparam logic [SzW:0]      SplitExtra = (SzW + 1)'(HeaderBytes + 8);
  localparam logic [SizeW-1:0]  InitSize   = SizeW'(HeapBytes - HeaderBytes);

  // Action codes.
  localparam logic [1:0] ActAlloc   = 2'd0;
  localparam logic [1:0] ActFree    = 2'd1;
  localparam logic [1:0] ActRealloc = 2'd2;
  localparam logic [1:0] ActUndef   = 2'd3;

  // Status codes.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StUnknown = 2'd2;
  localparam logic [1:0] StNull    = 2'd3;

  typedef struct packed {
    logic [StartW-1:0] start;
    logic [SizeW-1:0]  size;
    logic              free;
    logic [LinkW-1:0]  link;
  } entry_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_START, S_READ, S_CHECK, S_SPLIT, S_OLD, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_INIT, WR_NEW, WR_BLK, WR_TAKE, WR_FREE, WR_OLD
  } wr_sel_t;

  typedef enum logic [1:0] {
    R_NONE, R_STATUS, R_KEEP, R_ALLOC
  } res_op_t;

  typedef struct packed {
    logic       latch;
    logic       rd;
    logic       start_alloc;
    logic       start_find;
    logic       advance;
    logic       save_old;
    wr_sel_t    wr_sel;
    res_op_t    res_op;
    logic [1:0] status;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       has_ptr;
    logic       req_zero;
    logic       alloc_mode;
    logic       match;
    logic       keep_fits;
    logic       fits;
    logic       split_ok;
    logic       at_end;
    logic       is_move;
  } sts_t;

endpackage

@@ rtl/ffsa_ctrl.sv @@
`timescale 1ns / 1ps
module ffsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ffsa_pkg::sts_t sts,
  output ffsa_pkg::cmd_t cmd
);
  import ffsa_pkg::*;

  state_t state, state_next;
  logic   out_pending;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag, set on load and cleared on a completed transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_pending <= 1'b0;
    end else if (cmd.out_load) begin
      out_pending <= 1'b1;
    end else if (out_ready) begin
      out_pending <= 1'b0;
    end
  end

  assign out_valid = out_pending;
  assign in_ready  = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wr_sel = WR_NONE;
    cmd.res_op = R_NONE;
    cmd.status = StOk;
    case (state)
      S_INIT: begin
        cmd.wr_sel = WR_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.act == ActAlloc || (sts.act == ActRealloc && !sts.has_ptr)) begin
          if (sts.req_zero) begin
            cmd.res_op = R_STATUS;
            cmd.status = StNoFit;
            state_next = S_DONE;
          end else begin
            cmd.start_alloc = 1'b1;
            state_next      = S_READ;
          end
        end else if (sts.act == ActFree) begin
          if (!sts.has_ptr) begin
            cmd.res_op = R_STATUS;
            cmd.status = StNull;
            state_next = S_DONE;
          end else begin
            cmd.start_find = 1'b1;
            state_next     = S_READ;
          end
        end else if (sts.act == ActRealloc) begin
          cmd.start_find = 1'b1;
          state_next     = S_READ;
        end else begin
          cmd.res_op = R_STATUS;
          cmd.status = StNoFit;
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.alloc_mode) begin
          if (sts.fits) begin
            if (sts.split_ok) begin
              cmd.wr_sel = WR_NEW;
              state_next = S_SPLIT;
            end else begin
              cmd.wr_sel = WR_TAKE;
              cmd.res_op = R_ALLOC;
              state_next = sts.is_move ? S_OLD : S_DONE;
            end
          end else if (sts.at_end) begin
            cmd.res_op = R_STATUS;
            cmd.status = StNoFit;
            state_next = S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end else begin
          if (sts.match) begin
            if (sts.act == ActFree) begin
              cmd.wr_sel = WR_FREE;
              cmd.res_op = R_STATUS;
              cmd.status = StOk;
              state_next = S_DONE;
            end else if (sts.keep_fits) begin
              cmd.res_op = R_KEEP;
              state_next = S_DONE;
            end else begin
              cmd.save_old    = 1'b1;
              cmd.start_alloc = 1'b1;
              state_next      = S_READ;
            end
          end else if (sts.at_end) begin
            cmd.res_op = R_STATUS;
            cmd.status = StUnknown;
            state_next = S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      S_SPLIT: begin
        cmd.wr_sel = WR_BLK;
        cmd.res_op = R_ALLOC;
        state_next = sts.is_move ? S_OLD : S_DONE;
      end
      S_OLD: begin
        cmd.wr_sel = WR_OLD;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_pending || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ffsa_datapath.sv @@
`timescale 1ns / 1ps
module ffsa_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ffsa_pkg::InDataW-1:0]  in_data,
  output logic [ffsa_pkg::OutDataW-1:0] out_data,
  input  ffsa_pkg::cmd_t                cmd,
  output ffsa_pkg::sts_t                sts
);
  import ffsa_pkg::*;

  entry_t            mem [MaxBlocks];
  entry_t            cur;
  entry_t            old_ent;
  entry_t            wdata;
  logic [AddrW-1:0]  cursor;
  logic [AddrW-1:0]  old_idx;
  logic [AddrW-1:0]  waddr;
  logic              we;
  logic [LinkW-1:0]  count;
  logic [1:0]        act;
  logic              has_ptr;
  logic [StartW-1:0] off;
  logic [ReqW-1:0]   req;
  logic [SzW-1:0]    sz;
  logic [SzW-1:0]    req_round;
  logic              alloc_mode;
  logic              is_move;
  logic [1:0]        res_status;
  logic              res_granted;
  logic [StartW-1:0] res_offset;
  logic              res_moved;
  logic [SizeW-1:0]  res_copy;
  logic [1:0]        o_status;
  logic              o_granted;
  logic [StartW-1:0] o_offset;
  logic              o_moved;
  logic [SizeW-1:0]  o_copy;
  logic [StartW:0]   cur_data_off;

  assign req_round    = (SzW'(in_data[51:27]) + SzW'(7)) & ~SzW'(7);
  assign cur_data_off = {1'b0, cur.start} + (StartW + 1)'(HeaderBytes);

  // Request registers and walk bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act     <= in_data[1:0];
      has_ptr <= in_data[2];
      off     <= in_data[26:3];
      req     <= in_data[51:27];
      sz      <= req_round;
    end
    if (cmd.start_alloc || cmd.start_find) begin
      cursor <= '0;
    end else if (cmd.advance) begin
      cursor <= cur.link[AddrW-1:0];
    end
    if (cmd.save_old) begin
      old_idx <= cursor;
      old_ent <= cur;
    end
  end

  // Mode flags and table fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_mode <= 1'b0;
      is_move    <= 1'b0;
      count      <= LinkW'(1);
    end else begin
      if (cmd.latch) begin
        alloc_mode <= 1'b0;
        is_move    <= 1'b0;
      end else if (cmd.start_alloc) begin
        alloc_mode <= 1'b1;
      end
      if (cmd.save_old) begin
        is_move <= 1'b1;
      end
      if (cmd.wr_sel == WR_BLK) begin
        count <= count + LinkW'(1);
      end
    end
  end

  // Block table write selection.
  always_comb begin
    we    = 1'b1;
    waddr = cursor;
    wdata = cur;
    case (cmd.wr_sel)
      WR_INIT: begin
        waddr = '0;
        wdata = '{start: '0, size: InitSize, free: 1'b1, link: EndMark};
      end
      WR_NEW: begin
        waddr       = count[AddrW-1:0];
        wdata.start = cur_data_off[StartW-1:0] + sz[StartW-1:0];
        wdata.size  = cur.size - sz[SizeW-1:0] - HdrSize;
        wdata.free  = 1'b1;
        wdata.link  = cur.link;
      end
      WR_BLK: begin
        wdata.size = sz[SizeW-1:0];
        wdata.free = 1'b0;
        wdata.link = count;
      end
      WR_TAKE: wdata.free = 1'b0;
      WR_FREE: wdata.free = 1'b1;
      WR_OLD: begin
        waddr      = old_idx;
        wdata      = old_ent;
        wdata.free = 1'b1;
      end
      default: we = 1'b0;
    endcase
  end

  // Block table memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      cur <= mem[cursor];
    end
  end

  // Result of the current request.
  always_ff @(posedge clk) begin
    case (cmd.res_op)
      R_STATUS: begin
        res_status  <= cmd.status;
        res_granted <= 1'b0;
        res_offset  <= '0;
        res_moved   <= 1'b0;
        res_copy    <= '0;
      end
      R_KEEP: begin
        res_status  <= StOk;
        res_granted <= 1'b1;
        res_offset  <= off;
        res_moved   <= 1'b0;
        res_copy    <= '0;
      end
      R_ALLOC: begin
        res_status  <= StOk;
        res_granted <= 1'b1;
        res_offset  <= cur_data_off[StartW-1:0];
        res_moved   <= is_move;
        res_copy    <= is_move ? old_ent.size : '0;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      o_status  <= res_status;
      o_granted <= res_granted;
      o_offset  <= res_offset;
      o_moved   <= res_moved;
      o_copy    <= res_copy;
    end
  end

  assign out_data = {3'b000, o_copy, o_moved, o_offset, o_granted, o_status};

  // Status toward the controller.
  always_comb begin
    sts.act        = act;
    sts.has_ptr    = has_ptr;
    sts.req_zero   = (req == '0);
    sts.alloc_mode = alloc_mode;
    sts.match      = (cur_data_off == {1'b0, off});
    sts.keep_fits  = (cur.size >= req);
    sts.fits       = cur.free && ({1'b0, cur.size} >= sz);
    sts.split_ok   = ({2'b00, cur.size} > ({1'b0, sz} + SplitExtra)) && (count != EndMark);
    sts.at_end     = (cur.link == EndMark);
    sts.is_move    = is_move;
  end

endmodule

@@ rtl/first_fit_split_allocator.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_axis    in         request: action, has_pointer, offset, request_bytes
// m_axis    out        response: status, granted, result_offset, moved, copy_bytes
//
// Each block visited in the address-ordered chain costs a read of the block table
// memory and then a compare step. A request holds off the input while it walks the
// chain, plus a split step and a step that frees the old block of a move; a moving
// reallocate walks twice.
// After reset the initial free block is written before the first request.
// A finished response waits in an output register; the next request is taken meanwhile,
// and its own response then waits until the earlier transfer completes.
module first_fit_split_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // action[1:0], has_pointer[2], offset[26:3], request_bytes[51:27], zero fill
  input  logic [ffsa_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[1:0], granted[2], result_offset[26:3], moved[27], copy_bytes[52:28], zero fill
  output logic [ffsa_pkg::OutDataW-1:0] m_axis_tdata
);
  import ffsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffsa_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
